FILE: rtl/kvt_pkg.sv
package kvt_pkg;

   // Default sizes of the table.
   localparam int ENTRIES_DEFAULT       = 16;
   localparam int KEY_BYTES_DEFAULT     = 8;
   localparam int PAYLOAD_BYTES_DEFAULT = 8;

   // Configuration register indexes.
   localparam logic [1:0] CSR_CAPACITY_LIMIT    = 2'd0;
   localparam logic [1:0] CSR_MAX_KEY_BYTES     = 2'd1;
   localparam logic [1:0] CSR_MAX_PAYLOAD_BYTES = 2'd2;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_GET    = 2'd1,
      OP_UPDATE = 2'd2,
      OP_DELETE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STATUS_OK           = 3'd0,
      STATUS_FULL         = 3'd1,
      STATUS_KEY_LONG     = 3'd2,
      STATUS_PAYLOAD_LONG = 3'd3,
      STATUS_NOT_FOUND    = 3'd4
   } status_type;

   typedef struct packed {
      op_type      op;
      logic [63:0] key;
      logic [3:0]  key_length;
      logic [63:0] payload;
      logic [3:0]  payload_length;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [63:0] found_payload;
      logic [3:0]  found_payload_length;
      logic [4:0]  entry_count;
   } rsp_type;

   // Commands broadcast from the controller to every cell of the chain.
   typedef struct packed {
      logic write;
      logic update;
      logic remove;
   } cell_cmd_type;

   // Mask that keeps the low nbytes bytes of a 64-bit word.
   function automatic logic [63:0] byte_mask(input logic [3:0] nbytes);
      logic [63:0] m;
      m = '0;
      for (int b = 0; b < 8; b++) begin
         m[b*8 +: 8] = {8{4'(b) < nbytes}};
      end
      return m;
   endfunction

endpackage

FILE: rtl/key_value_table_linear.sv
// Linear key-value table kept in insertion order, built as a chain of
// ENTRIES cells, one entry per cell.
// Requests: a request is taken on a rising edge with start high and busy
// low. op selects insert, get, update or delete; key and payload arrive
// zero padded with their byte lengths.
// Results: each request gives one result, shown on rsp_data for exactly one
// cycle while rsp_valid is high. The receiver cannot stall; nothing waits.
// Timing: an insert is checked in ST_EVAL and its result is registered
// into rsp_data. Get, update and delete pass from ST_EVAL through ST_WAVE,
// where the first-match flag moves one cell per cycle down the chain, to
// ST_DONE, which registers the result. busy stays high until the result
// shows, so the next request may follow in the cycle of the result.
// Configuration: csr_write_enable writes csr_write_data into the register
// csr_index (capacity limit, key length limit, payload length limit) on
// the clock edge; it should be written only while the block is idle.
// Reset: synchronous and active high. The entry count goes to zero and the
// limits go to their defaults; entry contents are not cleared and are
// never read below the count before they are written.
module key_value_table_linear import kvt_pkg::*; #(
   parameter int ENTRIES       = ENTRIES_DEFAULT,
   parameter int KEY_BYTES     = KEY_BYTES_DEFAULT,
   parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [4:0] csr_write_data
);

   localparam int KW   = KEY_BYTES * 8;
   localparam int PW   = PAYLOAD_BYTES * 8;
   localparam int CW   = $clog2(ENTRIES + 1);
   localparam int CMPW = (CW > 5) ? CW : 5;
   localparam int WW   = $clog2(ENTRIES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_WAVE,
      ST_DONE
   } state_type;

   state_type     state_ff,    state_in;
   req_type       req_ff,      req_in;
   logic [CW-1:0] count_ff,    count_in;
   logic [WW-1:0] wave_ff,     wave_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff,      rsp_in;
   logic [4:0]    cap_ff;
   logic [3:0]    max_key_ff;
   logic [3:0]    max_pay_ff;

   cell_cmd_type  cmd;
   logic [3:0]    klen_eff;
   logic [3:0]    plen_eff;
   logic [KW-1:0] req_key_m;
   logic [PW-1:0] req_pay_m;
   logic          table_full;
   logic          key_long;
   logic          pay_long;

   logic [KW-1:0] c_key  [ENTRIES];
   logic [3:0]    c_klen [ENTRIES];
   logic [PW-1:0] c_pay  [ENTRIES];
   logic [3:0]    c_plen [ENTRIES];
   logic          c_hit  [ENTRIES];
   logic [PW-1:0] c_hpay [ENTRIES];
   logic [3:0]    c_hplen[ENTRIES];

   // Request key and payload masked to their lengths, capped at the widths.
   assign klen_eff  = (req_ff.key_length > 4'(KEY_BYTES)) ?
                      4'(KEY_BYTES) : req_ff.key_length;
   assign plen_eff  = (req_ff.payload_length > 4'(PAYLOAD_BYTES)) ?
                      4'(PAYLOAD_BYTES) : req_ff.payload_length;
   assign req_key_m = KW'(req_ff.key & byte_mask(klen_eff));
   assign req_pay_m = PW'(req_ff.payload & byte_mask(plen_eff));

   // Insert checks, full before the length limits.
   assign table_full = (CMPW'(count_ff) >= CMPW'(cap_ff)) ||
                       (count_ff >= CW'(ENTRIES));
   assign key_long   = (req_ff.key_length > max_key_ff) ||
                       (req_ff.key_length > 4'(KEY_BYTES));
   assign pay_long   = (req_ff.payload_length > max_pay_ff) ||
                       (req_ff.payload_length > 4'(PAYLOAD_BYTES));

   // Sequencer: evaluate; an insert acts at once, other requests let the match walk the chain, then act.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      wave_in      = wave_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (req_ff.op == OP_INSERT) begin
               rsp_in.found_payload        = '0;
               rsp_in.found_payload_length = '0;
               if (table_full) begin
                  rsp_in.status = STATUS_FULL;
               end else if (key_long) begin
                  rsp_in.status = STATUS_KEY_LONG;
               end else if (pay_long) begin
                  rsp_in.status = STATUS_PAYLOAD_LONG;
               end else begin
                  rsp_in.status = STATUS_OK;
                  cmd.write     = 1'b1;
                  count_in      = count_ff + 1'b1;
               end
               rsp_in.entry_count = 5'(count_in);
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end else begin
               wave_in  = WW'(ENTRIES - 1);
               state_in = ST_WAVE;
            end
         end
         ST_WAVE: begin
            if (wave_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               wave_in = wave_ff - 1'b1;
            end
         end
         ST_DONE: begin
            rsp_in.found_payload        = '0;
            rsp_in.found_payload_length = '0;
            if (!c_hit[ENTRIES-1]) begin
               rsp_in.status = STATUS_NOT_FOUND;
            end else begin
               rsp_in.status = STATUS_OK;
               case (req_ff.op)
                  OP_GET: begin
                     rsp_in.found_payload        = 64'(c_hpay[ENTRIES-1]);
                     rsp_in.found_payload_length = c_hplen[ENTRIES-1];
                  end
                  OP_UPDATE: cmd.update = 1'b1;
                  OP_DELETE: begin
                     cmd.remove = 1'b1;
                     count_in   = count_ff - 1'b1;
                  end
                  default: ;
               endcase
            end
            rsp_in.entry_count = 5'(count_in);
            rsp_valid_in       = 1'b1;
            state_in           = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff  <= req_in;
      wave_ff <= wave_in;
      rsp_ff  <= rsp_in;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff     <= 5'd16;
         max_key_ff <= 4'd8;
         max_pay_ff <= 4'd8;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CAPACITY_LIMIT:    cap_ff     <= csr_write_data;
            CSR_MAX_KEY_BYTES:     max_key_ff <= csr_write_data[3:0];
            CSR_MAX_PAYLOAD_BYTES: max_pay_ff <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   // Chain of entry cells; the last cell shifts from itself.
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic          p_hit;
      logic [PW-1:0] p_pay;
      logic [3:0]    p_plen;
      logic [KW-1:0] n_key;
      logic [3:0]    n_klen;
      logic [PW-1:0] n_pay;
      logic [3:0]    n_plen;

      if (i == 0) begin : g_head
         assign p_hit  = 1'b0;
         assign p_pay  = '0;
         assign p_plen = '0;
      end else begin : g_link
         assign p_hit  = c_hit[i-1];
         assign p_pay  = c_hpay[i-1];
         assign p_plen = c_hplen[i-1];
      end

      if (i == ENTRIES - 1) begin : g_tail
         assign n_key  = c_key[i];
         assign n_klen = c_klen[i];
         assign n_pay  = c_pay[i];
         assign n_plen = c_plen[i];
      end else begin : g_next
         assign n_key  = c_key[i+1];
         assign n_klen = c_klen[i+1];
         assign n_pay  = c_pay[i+1];
         assign n_plen = c_plen[i+1];
      end

      kvt_cell #(
         .IDX (i),
         .KW  (KW),
         .PW  (PW),
         .CW  (CW)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .count     (count_ff),
         .req_key   (req_key_m),
         .req_klen  (req_ff.key_length),
         .req_pay   (req_pay_m),
         .req_plen  (req_ff.payload_length),
         .prev_hit  (p_hit),
         .prev_pay  (p_pay),
         .prev_plen (p_plen),
         .next_key  (n_key),
         .next_klen (n_klen),
         .next_pay  (n_pay),
         .next_plen (n_plen),
         .own_key   (c_key[i]),
         .own_klen  (c_klen[i]),
         .own_pay   (c_pay[i]),
         .own_plen  (c_plen[i]),
         .hit       (c_hit[i]),
         .hit_pay   (c_hpay[i]),
         .hit_plen  (c_hplen[i])
      );
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/kvt_cell.sv
// One table entry. The cell compares its entry with the broadcast key, and
// passes "an earlier entry matched" plus the first matching payload to the
// next cell once per cycle, so the first match ripples down the chain.
module kvt_cell import kvt_pkg::*; #(
   parameter int IDX = 0,
   parameter int KW  = 64,
   parameter int PW  = 64,
   parameter int CW  = 5
) (
   input  logic         clock,
   input  cell_cmd_type cmd,
   input  logic [CW-1:0] count,
   input  logic [KW-1:0] req_key,
   input  logic [3:0]    req_klen,
   input  logic [PW-1:0] req_pay,
   input  logic [3:0]    req_plen,
   input  logic          prev_hit,
   input  logic [PW-1:0] prev_pay,
   input  logic [3:0]    prev_plen,
   input  logic [KW-1:0] next_key,
   input  logic [3:0]    next_klen,
   input  logic [PW-1:0] next_pay,
   input  logic [3:0]    next_plen,
   output logic [KW-1:0] own_key,
   output logic [3:0]    own_klen,
   output logic [PW-1:0] own_pay,
   output logic [3:0]    own_plen,
   output logic          hit,
   output logic [PW-1:0] hit_pay,
   output logic [3:0]    hit_plen
);

   logic [KW-1:0] key_ff,      key_in;
   logic [3:0]    klen_ff,     klen_in;
   logic [PW-1:0] pay_ff,      pay_in;
   logic [3:0]    plen_ff,     plen_in;
   logic          match_ff,    match_in;
   logic          hit_ff,      hit_in;
   logic [PW-1:0] hit_pay_ff,  hit_pay_in;
   logic [3:0]    hit_plen_ff, hit_plen_in;
   logic          live;
   logic          first;

   // Only entries below the count take part in a search.
   assign live     = CW'(IDX) < count;
   assign match_in = live && (klen_ff == req_klen) && (key_ff == req_key);

   // Prefix of the chain: a hit at or before this cell, and its payload.
   assign hit_in      = prev_hit | match_ff;
   assign hit_pay_in  = prev_hit ? prev_pay  : pay_ff;
   assign hit_plen_in = prev_hit ? prev_plen : plen_ff;
   assign first       = hit_ff & ~prev_hit;

   // Entry contents: insert at the count, update the first match, or shift
   // down from the neighbor when at or after the removed entry.
   always_comb begin
      key_in  = key_ff;
      klen_in = klen_ff;
      pay_in  = pay_ff;
      plen_in = plen_ff;
      if (cmd.write && (count == CW'(IDX))) begin
         key_in  = req_key;
         klen_in = req_klen;
         pay_in  = req_pay;
         plen_in = req_plen;
      end else if (cmd.update && first) begin
         pay_in  = req_pay;
         plen_in = req_plen;
      end else if (cmd.remove && hit_ff) begin
         key_in  = next_key;
         klen_in = next_klen;
         pay_in  = next_pay;
         plen_in = next_plen;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      klen_ff     <= klen_in;
      pay_ff      <= pay_in;
      plen_ff     <= plen_in;
      match_ff    <= match_in;
      hit_ff      <= hit_in;
      hit_pay_ff  <= hit_pay_in;
      hit_plen_ff <= hit_plen_in;
   end

   assign own_key  = key_ff;
   assign own_klen = klen_ff;
   assign own_pay  = pay_ff;
   assign own_plen = plen_ff;
   assign hit      = hit_ff;
   assign hit_pay  = hit_pay_ff;
   assign hit_plen = hit_plen_ff;

endmodule

FILE: tb/key_value_table_linear_tb.sv
module key_value_table_linear_tb import kvt_pkg::*; ();

   localparam int TABLE_ENTRIES   = ENTRIES_DEFAULT;
   localparam int KEY_BYTES_MAX   = KEY_BYTES_DEFAULT;
   localparam int PAYLOAD_MAX     = PAYLOAD_BYTES_DEFAULT;
   localparam int RANDOM_REQUESTS = 950;
   localparam int PHASES          = 7;
   localparam int IDLE_SETTLE     = 4;
   localparam int TAIL_CYCLES     = TABLE_ENTRIES + 8;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int PRINT_LIMIT     = 100;
   localparam int POOL_SIZE       = 8;

   // Work items for the request driver: a table request, a register write
   // (issued only once the block is idle), or a hold until all replies arrive.
   typedef enum logic [1:0] {
      STEP_REQUEST,
      STEP_CSR,
      STEP_DRAIN
   } step_kind_type;

   typedef struct {
      step_kind_type kind;
      req_type       req;
      logic [1:0]    csr_sel;
      logic [4:0]    csr_value;
   } table_step_type;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       start            = 1'b0;
   logic       busy;
   req_type    req_data         = '0;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_write_enable = 1'b0;
   logic [1:0] csr_index        = CSR_CAPACITY_LIMIT;
   logic [4:0] csr_write_data   = '0;

   table_step_type table_ops[$];
   rsp_type        pending_replies[$];

   // Shadow copy of the table contents and limits.
   logic [63:0] row_key [TABLE_ENTRIES];
   logic [3:0]  row_key_len [TABLE_ENTRIES];
   logic [63:0] row_payload [TABLE_ENTRIES];
   logic [3:0]  row_payload_len [TABLE_ENTRIES];
   int          row_count     = 0;
   logic [4:0]  cap_limit     = 5'd16;
   logic [3:0]  key_limit     = 4'd8;
   logic [3:0]  payload_limit = 4'd8;

   // Keys that random requests reuse so that lookups find something.
   logic [63:0] pool_key [POOL_SIZE];
   logic [3:0]  pool_len [POOL_SIZE];

   logic taken          = 1'b0;
   int   gap_left       = 0;
   int   burst_left     = 0;
   int   quiet_cycles   = 0;
   int   cycle_count    = 0;
   int   mismatch_count = 0;

   key_value_table_linear u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] low_bytes_mask(input int nbytes);
      if (nbytes >= 8) return '1;
      return (64'd1 << (nbytes * 8)) - 64'd1;
   endfunction

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // Applies one request to the shadow table and returns the reply it gives.
   function automatic rsp_type apply_table_request(input req_type r);
      rsp_type     o;
      int          hit;
      int          i;
      int          cap;
      int          klim;
      int          plim;
      logic [63:0] k;
      o = '0;
      o.status = STATUS_OK;
      if (r.op == OP_INSERT) begin
         cap  = (int'(cap_limit) < TABLE_ENTRIES) ? int'(cap_limit) : TABLE_ENTRIES;
         klim = (int'(key_limit) < KEY_BYTES_MAX) ? int'(key_limit) : KEY_BYTES_MAX;
         plim = (int'(payload_limit) < PAYLOAD_MAX) ? int'(payload_limit) : PAYLOAD_MAX;
         // The full check wins over both length checks.
         if (row_count >= cap) begin
            o.status = STATUS_FULL;
         end else if (int'(r.key_length) > klim) begin
            o.status = STATUS_KEY_LONG;
         end else if (int'(r.payload_length) > plim) begin
            o.status = STATUS_PAYLOAD_LONG;
         end else begin
            row_key[row_count]         = r.key & low_bytes_mask(int'(r.key_length));
            row_key_len[row_count]     = r.key_length;
            row_payload[row_count]     = r.payload & low_bytes_mask(int'(r.payload_length));
            row_payload_len[row_count] = r.payload_length;
            row_count = row_count + 1;
         end
      end else begin
         // First entry whose length and masked key bytes both match.
         hit = -1;
         k = r.key & low_bytes_mask(int'(r.key_length));
         for (i = 0; i < row_count; i++) begin
            if (hit < 0 && row_key_len[i] == r.key_length && row_key[i] == k) hit = i;
         end
         if (hit < 0) begin
            o.status = STATUS_NOT_FOUND;
         end else if (r.op == OP_GET) begin
            o.found_payload        = row_payload[hit];
            o.found_payload_length = row_payload_len[hit];
         end else if (r.op == OP_UPDATE) begin
            // The update length is stored raw and never checked.
            row_payload[hit]     = r.payload & low_bytes_mask(int'(r.payload_length));
            row_payload_len[hit] = r.payload_length;
         end else begin
            for (i = hit; i + 1 < row_count; i++) begin
               row_key[i]         = row_key[i + 1];
               row_key_len[i]     = row_key_len[i + 1];
               row_payload[i]     = row_payload[i + 1];
               row_payload_len[i] = row_payload_len[i + 1];
            end
            row_count = row_count - 1;
         end
      end
      o.entry_count = 5'(row_count);
      return o;
   endfunction

   function automatic void push_request(input op_type op, input logic [63:0] key,
                                        input int klen, input logic [63:0] pay,
                                        input int plen);
      table_step_type s;
      s.kind                 = STEP_REQUEST;
      s.req.op               = op;
      s.req.key              = key;
      s.req.key_length       = 4'(klen);
      s.req.payload          = pay;
      s.req.payload_length   = 4'(plen);
      s.csr_sel              = CSR_CAPACITY_LIMIT;
      s.csr_value            = '0;
      table_ops.push_back(s);
   endfunction

   function automatic void push_csr(input logic [1:0] sel, input int value);
      table_step_type s;
      s.kind      = STEP_CSR;
      s.req       = '0;
      s.csr_sel   = sel;
      s.csr_value = 5'(value);
      table_ops.push_back(s);
   endfunction

   function automatic void push_drain();
      table_step_type s;
      s.kind      = STEP_DRAIN;
      s.req       = '0;
      s.csr_sel   = CSR_CAPACITY_LIMIT;
      s.csr_value = '0;
      table_ops.push_back(s);
   endfunction

   // Random request: mostly keys from the pool, sometimes with stray bytes
   // above the key length, and otherwise a fresh random key.
   function automatic void push_random_request(input int insert_weight);
      op_type      op;
      int          pick;
      int          klen;
      int          j;
      logic [63:0] key;
      pick = $urandom_range(0, 99);
      if (pick < insert_weight) begin
         op = OP_INSERT;
      end else begin
         case ((pick - insert_weight) % 3)
            0:       op = OP_GET;
            1:       op = OP_UPDATE;
            default: op = OP_DELETE;
         endcase
      end
      if ($urandom_range(0, 9) < 8) begin
         j    = $urandom_range(0, POOL_SIZE - 1);
         key  = pool_key[j];
         klen = int'(pool_len[j]);
      end else begin
         klen = $urandom_range(0, 8);
         key  = random_word() & low_bytes_mask(klen);
      end
      if ($urandom_range(0, 7) == 0) key = key | (random_word() & ~low_bytes_mask(klen));
      push_request(op, key, klen, random_word(), $urandom_range(0, 8));
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT) $display("MISMATCH cycle %0d: %s", cycle_count, what);
      mismatch_count = mismatch_count + 1;
   endtask

   // Request driver: changes inputs on the falling edge, one assignment per
   // signal per edge.
   always @(negedge clock) begin : drive_requests
      logic       next_start;
      req_type    next_req;
      logic       next_we;
      logic [1:0] next_sel;
      logic [4:0] next_value;
      next_start = start;
      next_req   = req_data;
      next_we    = 1'b0;
      next_sel   = csr_index;
      next_value = csr_write_data;
      if (pending_replies.size() == 0 && !start) quiet_cycles = quiet_cycles + 1;
      else quiet_cycles = 0;
      if (!reset) begin
         if (start && taken) next_start = 1'b0;
         if (!next_start) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
            end else if (table_ops.size() > 0) begin
               case (table_ops[0].kind)
                  STEP_REQUEST: begin
                     next_start = 1'b1;
                     next_req   = table_ops[0].req;
                     void'(table_ops.pop_front());
                     // Gap after this request: bursts of back-to-back
                     // requests mixed with random pauses.
                     if (burst_left > 0) begin
                        gap_left   = 0;
                        burst_left = burst_left - 1;
                     end else begin
                        gap_left = $urandom_range(0, 16);
                        if ($urandom_range(0, 31) == 0) burst_left = $urandom_range(8, 40);
                     end
                  end
                  STEP_CSR: begin
                     if (quiet_cycles >= IDLE_SETTLE && !busy) begin
                        next_we    = 1'b1;
                        next_sel   = table_ops[0].csr_sel;
                        next_value = table_ops[0].csr_value;
                        void'(table_ops.pop_front());
                     end
                  end
                  default: begin
                     if (pending_replies.size() == 0) void'(table_ops.pop_front());
                  end
               endcase
            end
         end
      end
      start            <= next_start;
      req_data         <= next_req;
      csr_write_enable <= next_we;
      csr_index        <= next_sel;
      csr_write_data   <= next_value;
   end

   // Reply monitor: checks each reply against the oldest prediction, then
   // tracks register writes and accepted requests on the same edge.
   always @(posedge clock) begin : watch_replies
      rsp_type want;
      if (reset) begin
         row_count     = 0;
         cap_limit     = 5'd16;
         key_limit     = 4'd8;
         payload_limit = 4'd8;
         pending_replies.delete();
         taken <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1) begin
            if (pending_replies.size() == 0) begin
               report_mismatch("reply with no request outstanding");
            end else begin
               want = pending_replies.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_data.status, want.status));
               if (rsp_data.found_payload !== want.found_payload)
                  report_mismatch($sformatf("found_payload got %h want %h",
                                            rsp_data.found_payload, want.found_payload));
               if (rsp_data.found_payload_length !== want.found_payload_length)
                  report_mismatch($sformatf("found_payload_length got %0d want %0d",
                                            rsp_data.found_payload_length,
                                            want.found_payload_length));
               if (rsp_data.entry_count !== want.entry_count)
                  report_mismatch($sformatf("entry_count got %0d want %0d",
                                            rsp_data.entry_count, want.entry_count));
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_CAPACITY_LIMIT:    cap_limit     = csr_write_data;
               CSR_MAX_KEY_BYTES:     key_limit     = csr_write_data[3:0];
               CSR_MAX_PAYLOAD_BYTES: payload_limit = csr_write_data[3:0];
               default: ;
            endcase
         end
         if (start && !busy) pending_replies.push_back(apply_table_request(req_data));
         taken <= start && !busy;
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin : run_test
      int          cap_plan [PHASES];
      int          key_plan [PHASES];
      int          pay_plan [PHASES];
      int          per_phase;
      int          p;
      int          n;
      logic [63:0] k3;
      logic [63:0] k8;
      cap_plan = '{16, 3, 0, 16, -1, 1, 16};
      key_plan = '{8, -1, 8, 0, -1, 8, 8};
      pay_plan = '{8, 8, -1, 8, 0, -1, 8};
      k3 = 64'h0000_0000_00A1_B2C3;
      k8 = '1;

      // Lookups on an empty table.
      push_request(OP_GET, k3, 3, 64'h0, 0);
      push_request(OP_DELETE, k3, 3, 64'h0, 0);
      push_request(OP_UPDATE, k3, 3, 64'h1, 1);
      // Empty key, full-width key and payload, and a key with stray upper bytes.
      push_request(OP_INSERT, 64'h0, 0, 64'h0, 0);
      push_request(OP_INSERT, k8, 8, '1, 8);
      push_request(OP_INSERT, 64'hFFFF_FFFF_FFA1_B2C3, 3, 64'h1122_3344_5566_7788, 2);
      push_request(OP_GET, k3, 3, 64'h0, 0);
      // Same bytes with a different length must not match.
      push_request(OP_GET, k3, 4, 64'h0, 0);
      push_request(OP_GET, 64'h0, 0, 64'h0, 0);
      push_request(OP_UPDATE, k8, 8, 64'h0123_4567_89AB_CDEF, 0);
      push_request(OP_GET, k8, 8, 64'h0, 0);
      // A duplicate key: delete removes the first, the second then shows.
      push_request(OP_INSERT, k3, 3, 64'h55, 1);
      push_request(OP_DELETE, k3, 3, 64'h0, 0);
      push_request(OP_GET, k3, 3, 64'h0, 0);
      push_request(OP_DELETE, 64'h0, 0, 64'h0, 0);

      // Tight length limits; the key check comes before the payload check,
      // and update ignores the payload limit.
      push_csr(CSR_MAX_KEY_BYTES, 2);
      push_csr(CSR_MAX_PAYLOAD_BYTES, 1);
      push_request(OP_INSERT, 64'h33_2211, 3, 64'hBEEF, 2);
      push_request(OP_INSERT, 64'h2211, 2, 64'hBEEF, 2);
      push_request(OP_INSERT, 64'h2211, 2, 64'hBEEF, 1);
      push_request(OP_UPDATE, k3, 3, '1, 8);
      push_request(OP_GET, k3, 3, 64'h0, 0);

      // Capacity below the entry count: inserts are full, even with a long
      // key, while lookups and deletes still work.
      push_csr(CSR_CAPACITY_LIMIT, 1);
      push_request(OP_INSERT, 64'h55_4433_2211, 5, 64'h0, 0);
      push_request(OP_GET, k8, 8, 64'h0, 0);
      push_request(OP_DELETE, k8, 8, 64'h0, 0);
      push_csr(CSR_CAPACITY_LIMIT, 0);
      push_request(OP_INSERT, 64'h0, 0, 64'h0, 0);
      push_csr(CSR_CAPACITY_LIMIT, 16);
      push_csr(CSR_MAX_KEY_BYTES, 8);
      push_csr(CSR_MAX_PAYLOAD_BYTES, 8);
      push_request(OP_INSERT, k8, 8, '1, 8);

      for (n = 0; n < POOL_SIZE; n++) begin
         pool_len[n] = (n == 0) ? 4'd0 : (n == POOL_SIZE - 1) ? 4'd8 : 4'($urandom_range(1, 8));
         pool_key[n] = random_word() & low_bytes_mask(int'(pool_len[n]));
      end

      // Random phases, each under its own limits and insert/remove balance.
      per_phase = RANDOM_REQUESTS / PHASES;
      for (p = 0; p < PHASES; p++) begin
         push_csr(CSR_CAPACITY_LIMIT, cap_plan[p] < 0 ? $urandom_range(0, 16) : cap_plan[p]);
         push_csr(CSR_MAX_KEY_BYTES, key_plan[p] < 0 ? $urandom_range(0, 8) : key_plan[p]);
         push_csr(CSR_MAX_PAYLOAD_BYTES, pay_plan[p] < 0 ? $urandom_range(0, 8) : pay_plan[p]);
         n = $urandom_range(25, 60);
         for (int i = 0; i < per_phase; i++) begin
            push_random_request(n);
            if ($urandom_range(0, 63) == 0) push_drain();
         end
      end
      push_drain();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (table_ops.size() != 0 || start || pending_replies.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
